FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, masked while reset is high.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked on every clock, reset included.
`define ASSERT_NXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/swfd_pkg.sv
// Package: shared types and constants of the sync word frame deframer.
`timescale 1ns / 1ps

package swfd_pkg;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   // Configuration register indexes
   localparam logic [1:0] CSR_SYNC_WORD   = 2'd0;
   localparam logic [1:0] CSR_MAX_PAYLOAD = 2'd1;

   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 64;
   localparam int MAX_PAYLOAD_W = 21;

   localparam logic [63:0]              SYNC_WORD_RESET   = 64'h6175746F63617221;
   localparam logic [MAX_PAYLOAD_W-1:0] MAX_PAYLOAD_RESET = 21'd1048556;

   // Header layout: four little-endian 32-bit words
   localparam int HEADER_BYTES = 16;
   localparam int HEADER_IDX_W = 4;

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // One result beat
   typedef struct packed {
      kind_type    kind;
      logic [31:0] version_word;
      logic [31:0] sequence_res;
      logic [31:0] action_code;
      logic [31:0] payload_length;
      logic [7:0]  payload_byte;
      logic        frame_end;
   } rsp_type;

   // A result beat with its valid mark, between front, queue and back
   typedef struct packed {
      logic    valid;
      rsp_type data;
   } beat_type;

endpackage

FILE: rtl/swfd_front.sv
// Front: takes bytes, hunts the sync word, collects the header, classifies payload.
`timescale 1ns / 1ps

module swfd_front #(
   parameter int SYNC_BYTES = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [swfd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [swfd_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                 accept,
   input  logic [7:0]                           rx_byte,
   output swfd_pkg::beat_type                   push
);

   localparam int WIN_W  = 8 * SYNC_BYTES;
   localparam int FILL_W = $clog2(SYNC_BYTES + 1);
   localparam int MP_W   = swfd_pkg::MAX_PAYLOAD_W;
   localparam int HI_W   = swfd_pkg::HEADER_IDX_W;

   typedef enum logic [1:0] {
      ST_HUNT = 2'd0,
      ST_HEAD = 2'd1,
      ST_PAY  = 2'd2
   } state_type;

   state_type         state_ff, state_in;
   logic [WIN_W-1:0]  window_ff, window_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [HI_W-1:0]   hidx_ff, hidx_in;
   logic [31:0]       held_ff [4];
   logic [31:0]       held_in [4];
   logic [MP_W-1:0]   left_ff, left_in;
   logic [63:0]       sync_word_ff, sync_word_in;
   logic [MP_W-1:0]   max_pay_ff, max_pay_in;

   logic [WIN_W+7:0]  shifted;
   logic [31:0]       new_word;
   logic [1:0]        lane;
   logic [MP_W-1:0]   left_dec;

   // Configuration writes; unknown indexes are dropped
   always_comb begin
      sync_word_in = sync_word_ff;
      max_pay_in   = max_pay_ff;
      if (csr_wr_en) begin
         case (csr_index)
            swfd_pkg::CSR_SYNC_WORD:   sync_word_in = csr_wdata;
            swfd_pkg::CSR_MAX_PAYLOAD: max_pay_in   = csr_wdata[MP_W-1:0];
            default: ;
         endcase
      end
   end

   // Per-byte state update and result classification
   always_comb begin
      state_in  = state_ff;
      window_in = window_ff;
      fill_in   = fill_ff;
      hidx_in   = hidx_ff;
      left_in   = left_ff;
      for (int i = 0; i < 4; i++) held_in[i] = held_ff[i];
      push      = '0;
      shifted   = {window_ff, rx_byte};
      lane      = hidx_ff[1:0];
      new_word  = (lane == 2'd0) ? {24'd0, rx_byte} : held_ff[hidx_ff[3:2]];
      new_word[8*lane +: 8] = rx_byte;
      left_dec  = (left_ff != '0) ? left_ff - 1'b1 : left_ff;

      if (accept) begin
         case (state_ff)
            ST_HEAD: begin
               held_in[hidx_ff[3:2]] = new_word;
               if (hidx_ff != HI_W'(swfd_pkg::HEADER_BYTES - 1)) begin
                  hidx_in = hidx_ff + 1'b1;
               end else begin
                  hidx_in                  = '0;
                  push.valid               = 1'b1;
                  push.data.version_word   = held_in[0];
                  push.data.sequence_res   = held_in[1];
                  push.data.action_code    = held_in[2];
                  push.data.payload_length = held_in[3];
                  push.data.payload_byte   = 8'd0;
                  // oversize length: error beat and back to hunting
                  if (held_in[3] > {{(32-MP_W){1'b0}}, max_pay_ff}) begin
                     push.data.kind      = swfd_pkg::KIND_ERROR;
                     push.data.frame_end = 1'b1;
                     state_in            = ST_HUNT;
                     window_in           = '0;
                     fill_in             = '0;
                  end else if (held_in[3] == 32'd0) begin
                     push.data.kind      = swfd_pkg::KIND_HEADER;
                     push.data.frame_end = 1'b1;
                     state_in            = ST_HUNT;
                     window_in           = '0;
                     fill_in             = '0;
                  end else begin
                     push.data.kind      = swfd_pkg::KIND_HEADER;
                     push.data.frame_end = 1'b0;
                     left_in             = held_in[3][MP_W-1:0];
                     state_in            = ST_PAY;
                  end
               end
            end
            ST_PAY: begin
               left_in                  = left_dec;
               push.valid               = 1'b1;
               push.data.kind           = swfd_pkg::KIND_PAYLOAD;
               push.data.version_word   = held_ff[0];
               push.data.sequence_res   = held_ff[1];
               push.data.action_code    = held_ff[2];
               push.data.payload_length = held_ff[3];
               push.data.payload_byte   = rx_byte;
               push.data.frame_end      = (left_dec == '0);
               // last payload byte: resume hunting
               if (left_dec == '0) begin
                  state_in  = ST_HUNT;
                  window_in = '0;
                  fill_in   = '0;
                  hidx_in   = '0;
               end
            end
            default: begin
               // shift the window, match once it is full
               state_in  = ST_HUNT;
               window_in = shifted[WIN_W-1:0];
               if (fill_ff != FILL_W'(SYNC_BYTES)) fill_in = fill_ff + 1'b1;
               if (fill_in == FILL_W'(SYNC_BYTES) &&
                   window_in == sync_word_ff[WIN_W-1:0]) begin
                  state_in  = ST_HEAD;
                  window_in = '0;
                  fill_in   = '0;
                  hidx_in   = '0;
               end
            end
         endcase
      end
   end

   // State and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_HUNT;
         window_ff    <= '0;
         fill_ff      <= '0;
         hidx_ff      <= '0;
         left_ff      <= '0;
         sync_word_ff <= swfd_pkg::SYNC_WORD_RESET;
         max_pay_ff   <= swfd_pkg::MAX_PAYLOAD_RESET;
         for (int i = 0; i < 4; i++) held_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         fill_ff      <= fill_in;
         hidx_ff      <= hidx_in;
         left_ff      <= left_in;
         sync_word_ff <= sync_word_in;
         max_pay_ff   <= max_pay_in;
         for (int i = 0; i < 4; i++) held_ff[i] <= held_in[i];
      end
   end

endmodule

FILE: rtl/swfd_queue.sv
// Queue: short result FIFO between the front and the back.
`timescale 1ns / 1ps

module swfd_queue (
   input  logic               clock,
   input  logic               reset,
   input  swfd_pkg::beat_type push,
   input  logic               pop,
   output logic               full,
   output swfd_pkg::beat_type head
);

   localparam int DEPTH = swfd_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   swfd_pkg::rsp_type mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign do_push    = push.valid && !full;
   assign head.valid = (count_ff != '0);
   assign head.data  = mem_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !pop)
         count_in = count_ff + 1'b1;
      else if (pop && !do_push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store beats
   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push.data;
   end

endmodule

FILE: rtl/swfd_back.sv
// Back: output register that presents result beats to the receiver.
`timescale 1ns / 1ps

module swfd_back (
   input  logic               clock,
   input  logic               reset,
   input  swfd_pkg::beat_type head,
   output logic               pop,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output swfd_pkg::rsp_type  rsp_data
);

   logic              valid_ff, valid_in;
   swfd_pkg::rsp_type data_ff, data_in;

   // Load the next beat when the register is empty or being taken
   always_comb begin
      pop      = head.valid && (!valid_ff || rsp_ready);
      valid_in = valid_ff;
      data_in  = data_ff;
      if (pop) begin
         valid_in = 1'b1;
         data_in  = head.data;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

FILE: rtl/sync_word_frame_deframer_unit.sv
// Top level: sync word frame deframer with front, queue and back.
//
// Usage:
//   req_* carries one received byte per beat (valid/ready). The front hunts
//   for the sync word in a sliding window of the last SYNC_BYTES bytes, then
//   takes 16 header bytes (version, sequence, action, length, each 32-bit
//   little endian). rsp_* carries one header beat, then one beat per payload
//   byte; rsp_frame_end marks the final beat. A length above max_payload
//   gives a single error beat and hunting resumes.
//   csr_* writes sync_word (index 0) or max_payload (index 1);
//   other indexes are ignored. Write only while the block is idle.
// Timing:
//   One byte accepted per cycle while req_ready is high. The result of an
//   accepted byte is written into the queue, then passes through the output
//   register to rsp_*; the front compares and shifts each byte combinationally.
//   A four-beat queue and the output register decouple the sides: when the
//   receiver stalls, bytes are still taken until the queue fills, then
//   req_ready drops.
// Reset: synchronous, active high; hunting with an empty window, queue and
//   output register empty, registers back to their defaults.
`timescale 1ns / 1ps

module sync_word_frame_deframer_unit #(
   parameter int SYNC_BYTES = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [swfd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [swfd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_rx_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [1:0]                       rsp_kind,
   output logic [31:0]                      rsp_version_word,
   output logic [31:0]                      rsp_sequence_res,
   output logic [31:0]                      rsp_action_code,
   output logic [31:0]                      rsp_payload_length,
   output logic [7:0]                       rsp_payload_byte,
   output logic                             rsp_frame_end
);

   swfd_pkg::beat_type push;
   swfd_pkg::beat_type head;
   swfd_pkg::rsp_type  rsp_data;
   logic               full;
   logic               pop;
   logic               accept;

   assign req_ready = !full;
   assign accept    = req_valid && !full;

   swfd_front #(
      .SYNC_BYTES (SYNC_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .rx_byte   (req_rx_byte),
      .push      (push)
   );

   swfd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (full),
      .head  (head)
   );

   swfd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_kind           = rsp_data.kind;
   assign rsp_version_word   = rsp_data.version_word;
   assign rsp_sequence_res   = rsp_data.sequence_res;
   assign rsp_action_code    = rsp_data.action_code;
   assign rsp_payload_length = rsp_data.payload_length;
   assign rsp_payload_byte   = rsp_data.payload_byte;
   assign rsp_frame_end      = rsp_data.frame_end;

endmodule

FILE: rtl/swfd_checker.sv
// Checker: port-level assertions on the deframer, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module swfd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [31:0] rsp_payload_length,
   input logic [7:0]  rsp_payload_byte,
   input logic        rsp_frame_end
);

   logic        is_error;
   logic        is_payload;
   logic        stalled;
   logic [10:0] rsp_view;

   assign is_error   = rsp_valid && (rsp_kind == swfd_pkg::KIND_ERROR);
   assign is_payload = rsp_valid && (rsp_kind == swfd_pkg::KIND_PAYLOAD);
   assign stalled    = rsp_valid && !rsp_ready;
   assign rsp_view   = {rsp_kind, rsp_payload_byte, rsp_frame_end};

   // Reset empties the output side
   `ASSERT_NXT(a_reset_empty, clock, reset, !rsp_valid)

   // A stalled result beat keeps its kind, data byte and frame-end mark
   `ASSERT_IMP(a_rsp_hold, clock, reset, stalled, ##1 (rsp_valid && $stable(rsp_view)))

   // An oversize error always closes the frame
   `ASSERT_IMP(a_error_ends, clock, reset, is_error, rsp_frame_end)

   // Non-payload beats carry a zero data byte
   `ASSERT_IMP(a_byte_zero, clock, reset, rsp_valid && !is_payload, rsp_payload_byte == 8'd0)

   // An error length is never zero
   `ASSERT_IMP(a_error_len, clock, reset, is_error, rsp_payload_length != 32'd0)

endmodule

bind sync_word_frame_deframer_unit swfd_checker u_swfd_checker (.*);
